// ===== rtl/core/vrom_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vrom_pkg
// Shared types and codes for the voxel ray occupancy marker.
// ============================================================================
package vrom_pkg;

    localparam int COORD_W   = 16;
    localparam int VOX_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_CNT_W = 17;
    localparam int SQ_W      = 34;

    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // operation codes
    localparam logic [1:0] OP_HIT  = 2'd0;
    localparam logic [1:0] OP_FREE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // cell states
    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_FREE     = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOXEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQ,
        ST_NCNT,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_BOUND,
        ST_CDIV_WAIT,
        ST_ADDR,
        ST_MRD,
        ST_MWR,
        ST_NEXT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/vrom_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vrom_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
module vrom_div
    import vrom_pkg::*;
#(
    parameter int NUM_W = 27,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // one shift-subtract step
    always_comb
    begin
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/vrom_map.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vrom_map
// Voxel state memory, one write and one registered read port.
// ============================================================================
module vrom_map
    import vrom_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data
);

    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/voxel_ray_occupancy_marker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// voxel_ray_occupancy_marker
// 3-D occupancy map updated by ray casting, one op per input beat.
// ============================================================================
// Usage:
//   s_* carries one op per beat (hit ray, free ray or cell read); m_* returns
//   one result beat per op with the cell state, endpoint flag and counts.
//   cfg_wr_en/cfg_index/cfg_wdata write voxel size and bounds; write only
//   while the block is idle.
// Throughput:
//   One op at a time; s_tready is high only when idle. Every sample point
//   and every cell index of a ray goes through the single shared divider
//   (start, shift-subtract steps, done), and the sample count search
//   steps through the candidates one by one.
// Reset:
//   After rst_n the map memory is swept to unknown, one cell per cycle,
//   with s_tready low; config writes are taken meanwhile.
// Stall:
//   The result sits in an output register; a new op is accepted while it
//   waits, and that op holds at its end until the register is free.
// ============================================================================
module voxel_ray_occupancy_marker
    import vrom_pkg::*;
#(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 64,
    parameter int GRID_LAYERS = 16,
    parameter int MAX_SAMPLES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[1:0] origin_x[17:2] origin_y[33:18] origin_z[49:34] end_x[65:50]
    // end_y[81:66] end_z[97:82] cell_col[103:98] cell_row[109:104]
    // cell_layer[113:110], zero fill to 119
    input  logic [119:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cell_state[1:0] endpoint_marked[2] observed_count[19:3]
    // occupied_count[36:20], zero fill to 39
    output logic [39:0]          m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata
);

    localparam int CELLS  = GRID_COLS * GRID_ROWS * GRID_LAYERS;
    localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW0    = $clog2(CELLS + 1);
    localparam int CW     = (CW0 > OUT_CNT_W) ? CW0 : OUT_CNT_W;
    localparam int NW     = $clog2(MAX_SAMPLES + 1);
    localparam int TW     = NW + VOX_W;
    localparam int CMPW   = (2 * TW > SQ_W + 2) ? 2 * TW : SQ_W + 2;
    localparam int NUM_W  = COORD_W + NW;
    localparam int DEN_W  = (NW > VOX_W) ? NW : VOX_W;
    localparam int MAXD0  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int MAXD   = (MAXD0 > GRID_LAYERS) ? MAXD0 : GRID_LAYERS;
    localparam int CIW    = (MAXD > 1) ? $clog2(MAXD) : 1;

    // ---------------- registers ----------------
    state_t                    state_reg, state_next;
    logic [1:0]                op_reg, op_next;
    logic signed [COORD_W-1:0] o_reg [3];
    logic signed [COORD_W-1:0] o_next [3];
    logic signed [COORD_W-1:0] e_reg [3];
    logic signed [COORD_W-1:0] e_next [3];
    logic signed [COORD_W:0]   d_reg [3];
    logic signed [COORD_W:0]   d_next [3];
    logic [NUM_W-1:0]          acc_reg [3];
    logic [NUM_W-1:0]          acc_next [3];
    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [COORD_W-1:0] p_next [3];
    logic [CIW-1:0]            cidx_reg [3];
    logic [CIW-1:0]            cidx_next [3];
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [NW-1:0]             n_reg, n_next;
    logic [TW-1:0]             t_reg, t_next;
    logic [NW-1:0]             last_reg, last_next;
    logic [NW-1:0]             i_reg, i_next;
    logic [1:0]                ax_reg, ax_next;
    logic                      endp_reg, endp_next;
    logic                      end_mark_reg, end_mark_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic [CW-1:0]             obs_cnt_reg, obs_cnt_next;
    logic [CW-1:0]             occ_cnt_reg, occ_cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_state_reg, out_state_next;
    logic [1:0]                rd_state_reg, rd_state_next;
    logic                      out_end_reg, out_end_next;
    logic [OUT_CNT_W-1:0]      out_obs_reg, out_obs_next;
    logic [OUT_CNT_W-1:0]      out_occ_reg, out_occ_next;

    logic [VOX_W-1:0]          voxel_reg;
    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];

    // ---------------- datapath wires ----------------
    logic [VOX_W-1:0]          vox_eff;
    logic signed [COORD_W:0]   d_sel;
    logic [COORD_W:0]          abs_sel;
    logic [SQ_W-1:0]           d_sq;
    logic [2*TW-1:0]           t_sq;
    logic                      n_short;
    logic [COORD_W:0]          abs_d [3];
    logic signed [COORD_W-1:0] lo_sel, hi_sel, p_sel;
    logic signed [COORD_W:0]   off_s;
    logic [COORD_W+1:0]        pt_sum;
    logic [COORD_W:0]          q_lo;
    logic [NUM_W-1:0]          cells_sel;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [NUM_W-1:0]          div_quo;
    div_stat_t                 div_stat;
    logic                      map_wr_en, map_rd_en;
    logic [AW-1:0]             map_wr_addr;
    logic [1:0]                map_wr_data, map_rd_data;
    logic                      in_acc, out_load;
    logic [1:0]                in_op;
    logic [5:0]                in_col, in_row;
    logic [3:0]                in_lay;

    assign in_op  = s_tdata[1:0];
    assign in_col = s_tdata[103:98];
    assign in_row = s_tdata[109:104];
    assign in_lay = s_tdata[113:110];
    assign in_acc = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_obs_reg, out_end_reg, out_state_reg};

    // ---------------- units ----------------
    vrom_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    vrom_map #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (addr_reg),
        .rd_data (map_rd_data)
    );

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voxel_reg <= VOX_W'(200);
            lo_reg[0] <= -16'sd4000;
            hi_reg[0] <= 16'sd7000;
            lo_reg[1] <= -16'sd4500;
            hi_reg[1] <= 16'sd4500;
            lo_reg[2] <= 16'sd0;
            hi_reg[2] <= 16'sd2400;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VOXEL: voxel_reg <= cfg_wdata[VOX_W-1:0];
                REG_MIN_X: lo_reg[0] <= cfg_wdata;
                REG_MAX_X: hi_reg[0] <= cfg_wdata;
                REG_MIN_Y: lo_reg[1] <= cfg_wdata;
                REG_MAX_Y: hi_reg[1] <= cfg_wdata;
                REG_MIN_Z: lo_reg[2] <= cfg_wdata;
                REG_MAX_Z: hi_reg[2] <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            obs_cnt_reg   <= '0;
            occ_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            obs_cnt_reg   <= obs_cnt_next;
            occ_cnt_reg   <= occ_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        o_reg         <= o_next;
        e_reg         <= e_next;
        d_reg         <= d_next;
        acc_reg       <= acc_next;
        p_reg         <= p_next;
        cidx_reg      <= cidx_next;
        sq_reg        <= sq_next;
        n_reg         <= n_next;
        t_reg         <= t_next;
        last_reg      <= last_next;
        i_reg         <= i_next;
        ax_reg        <= ax_next;
        endp_reg      <= endp_next;
        end_mark_reg  <= end_mark_next;
        addr_reg      <= addr_next;
        rd_state_reg  <= rd_state_next;
        out_state_reg <= out_state_next;
        out_end_reg   <= out_end_next;
        out_obs_reg   <= out_obs_next;
        out_occ_reg   <= out_occ_next;
    end

    // ---------------- shared arithmetic ----------------
    always_comb
    begin
        vox_eff = (voxel_reg == '0) ? VOX_W'(1) : voxel_reg;
        for (int k = 0; k < 3; k++)
        begin
            abs_d[k] = d_reg[k][COORD_W] ? (COORD_W+1)'(-d_reg[k]) : d_reg[k];
        end
        unique case (ax_reg)
            2'd0:    begin d_sel = d_reg[0]; lo_sel = lo_reg[0]; hi_sel = hi_reg[0];
                     abs_sel = abs_d[0];
                     p_sel = p_reg[0]; cells_sel = NUM_W'(GRID_COLS); end
            2'd1:    begin d_sel = d_reg[1]; lo_sel = lo_reg[1]; hi_sel = hi_reg[1];
                     abs_sel = abs_d[1];
                     p_sel = p_reg[1]; cells_sel = NUM_W'(GRID_ROWS); end
            default: begin d_sel = d_reg[2]; lo_sel = lo_reg[2]; hi_sel = hi_reg[2];
                     abs_sel = abs_d[2];
                     p_sel = p_reg[2]; cells_sel = NUM_W'(GRID_LAYERS); end
        endcase
        d_sq    = abs_sel * abs_sel;
        t_sq    = t_reg * t_reg;
        n_short = (n_reg < NW'(MAX_SAMPLES)) &&
                  (CMPW'(t_sq) < CMPW'({sq_reg, 2'b00}));
        off_s   = {p_sel[COORD_W-1], p_sel} - {lo_sel[COORD_W-1], lo_sel};
        q_lo    = div_quo[COORD_W:0];
        pt_sum  = {{2{o_reg[ax_reg][COORD_W-1]}}, o_reg[ax_reg]} +
                  (d_sel[COORD_W] ? (COORD_W+2)'(-{1'b0, q_lo}) : {1'b0, q_lo});
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        o_next         = o_reg;
        e_next         = e_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        cidx_next      = cidx_reg;
        sq_next        = sq_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        ax_next        = ax_reg;
        endp_next      = endp_reg;
        end_mark_next  = end_mark_reg;
        addr_next      = addr_reg;
        clr_next       = clr_reg;
        obs_cnt_next   = obs_cnt_reg;
        occ_cnt_next   = occ_cnt_reg;
        rd_state_next  = rd_state_reg;
        out_state_next = out_state_reg;
        out_end_next   = out_end_reg;
        out_obs_next   = out_obs_reg;
        out_occ_next   = out_occ_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        div_start      = 1'b0;
        div_num        = acc_reg[ax_reg];
        div_den        = DEN_W'(n_reg);
        map_wr_en      = 1'b0;
        map_wr_addr    = addr_reg;
        map_wr_data    = CELL_FREE;
        map_rd_en      = 1'b0;

        unique case (state_reg)
            // sweep the map to unknown after reset
            ST_CLEAR:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = clr_reg;
                map_wr_data = CELL_UNKNOWN;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next       = in_op;
                    for (int k = 0; k < 3; k++)
                    begin
                        o_next[k] = s_tdata[2 + 16*k +: 16];
                        e_next[k] = s_tdata[50 + 16*k +: 16];
                        d_next[k] = {s_tdata[50 + 16*k + 15], s_tdata[50 + 16*k +: 16]} -
                                    {s_tdata[2 + 16*k + 15], s_tdata[2 + 16*k +: 16]};
                    end
                    cidx_next[0]  = CIW'(in_col);
                    cidx_next[1]  = CIW'(in_row);
                    cidx_next[2]  = CIW'(in_lay);
                    ax_next       = 2'd0;
                    sq_next       = '0;
                    endp_next     = 1'b0;
                    end_mark_next = 1'b0;
                    rd_state_next = CELL_UNKNOWN;
                    if (in_op == OP_HIT || in_op == OP_FREE)
                    begin
                        state_next = ST_SQ;
                    end
                    else if (in_op == OP_READ &&
                             (9'(in_col) < 9'(GRID_COLS)) &&
                             (9'(in_row) < 9'(GRID_ROWS)) &&
                             (9'(in_lay) < 9'(GRID_LAYERS)))
                    begin
                        state_next = ST_ADDR;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            // squared length, one axis per cycle
            ST_SQ:
            begin
                sq_next = sq_reg + d_sq;
                ax_next = ax_reg + 1'b1;
                if (ax_reg == 2'd2)
                begin
                    n_next = NW'(1);
                    t_next = TW'(vox_eff);
                    if (op_reg == OP_HIT && sq_next == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_NCNT;
                    end
                end
            end

            // least n with (n*vox)^2 >= 4*len^2, capped at MAX_SAMPLES
            ST_NCNT:
            begin
                if (n_short)
                begin
                    n_next = n_reg + 1'b1;
                    t_next = t_reg + TW'(vox_eff);
                end
                else
                begin
                    last_next = (op_reg == OP_HIT) ? n_reg - 1'b1 : n_reg;
                    i_next    = '0;
                    ax_next   = 2'd0;
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = '0;
                    end
                    state_next = ST_SDIV_GO;
                end
            end

            ST_SDIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_SDIV_WAIT;
            end

            // sample point: origin + trunc(d*i/n)
            ST_SDIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    p_next[ax_reg] = pt_sum[COORD_W-1:0];
                    if (ax_reg == 2'd2)
                    begin
                        ax_next    = 2'd0;
                        state_next = ST_BOUND;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = ST_SDIV_GO;
                    end
                end
            end

            // bounds check, then cell index (p - min) / voxel
            ST_BOUND:
            begin
                div_num = NUM_W'(unsigned'(off_s));
                div_den = DEN_W'(vox_eff);
                if (p_sel >= lo_sel && p_sel < hi_sel)
                begin
                    div_start  = 1'b1;
                    state_next = ST_CDIV_WAIT;
                end
                else
                begin
                    state_next = endp_reg ? ST_FINISH : ST_NEXT;
                end
            end

            ST_CDIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (div_quo >= cells_sel)
                    begin
                        state_next = endp_reg ? ST_FINISH : ST_NEXT;
                    end
                    else
                    begin
                        cidx_next[ax_reg] = div_quo[CIW-1:0];
                        if (ax_reg == 2'd2)
                        begin
                            state_next = ST_ADDR;
                        end
                        else
                        begin
                            ax_next    = ax_reg + 1'b1;
                            state_next = ST_BOUND;
                        end
                    end
                end
            end

            ST_ADDR:
            begin
                addr_next  = ((AW'(cidx_reg[2]) * AW'(GRID_ROWS) + AW'(cidx_reg[1])) *
                              AW'(GRID_COLS)) + AW'(cidx_reg[0]);
                state_next = ST_MRD;
            end

            ST_MRD:
            begin
                map_rd_en  = 1'b1;
                state_next = ST_MWR;
            end

            // read of one cell, and for rays its read-modify-write
            ST_MWR:
            begin
                if (op_reg == OP_READ)
                begin
                    rd_state_next = map_rd_data;
                    state_next    = ST_FINISH;
                end
                else if (endp_reg)
                begin
                    map_wr_en     = 1'b1;
                    map_wr_data   = CELL_OCCUPIED;
                    end_mark_next = 1'b1;
                    if (map_rd_data == CELL_UNKNOWN)
                    begin
                        obs_cnt_next = obs_cnt_reg + 1'b1;
                    end
                    if (map_rd_data != CELL_OCCUPIED)
                    begin
                        occ_cnt_next = occ_cnt_reg + 1'b1;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (map_rd_data == CELL_UNKNOWN)
                    begin
                        map_wr_en    = 1'b1;
                        obs_cnt_next = obs_cnt_reg + 1'b1;
                    end
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                ax_next = 2'd0;
                if (i_reg == last_reg)
                begin
                    if (op_reg == OP_HIT)
                    begin
                        endp_next  = 1'b1;
                        p_next     = e_reg;
                        state_next = ST_BOUND;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = acc_reg[k] + NUM_W'(abs_d[k]);
                    end
                    state_next = ST_SDIV_GO;
                end
            end

            // hand the result to the output register
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_state_next = rd_state_reg;
            out_end_next   = end_mark_reg;
            out_obs_next   = (obs_cnt_reg > CW'(COUNT_MAX)) ? COUNT_MAX :
                             obs_cnt_reg[OUT_CNT_W-1:0];
            out_occ_next   = (occ_cnt_reg > CW'(COUNT_MAX)) ? COUNT_MAX :
                             occ_cnt_reg[OUT_CNT_W-1:0];
        end
    end

    // ---------------- checks ----------------
    a_occ_le_obs: assert property (@(posedge clk) disable iff (!rst_n)
        occ_cnt_reg <= obs_cnt_reg)
        else $error("occupied count above observed count");

    a_obs_mono: assert property (@(posedge clk) disable iff (!rst_n)
        obs_cnt_reg >= $past(obs_cnt_reg))
        else $error("observed count went down");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_end_hit: assert property (@(posedge clk) disable iff (!rst_n)
        end_mark_reg && state_reg == ST_FINISH |-> op_reg == OP_HIT)
        else $error("endpoint mark on a non-hit op");

endmodule

// ===== tb/sv/tb_voxel_ray_occupancy_marker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_voxel_ray_occupancy_marker
// Self-checking bench for the voxel ray occupancy marker: a scoreboard keeps
// its own voxel map and counters, predicts every result beat from the
// accepted op beats and checks the outputs field by field, across several
// bound and voxel settings and several idle/stall mixes.
// ============================================================================
module tb_voxel_ray_occupancy_marker;
    import vrom_pkg::*;

    localparam int  N_COLS   = 64;
    localparam int  N_ROWS   = 64;
    localparam int  N_LAYERS = 16;
    localparam int  N_SAMP   = 64;
    localparam int  N_CELLS  = N_COLS * N_ROWS * N_LAYERS;
    localparam int  OP_NONE  = 3;
    localparam longint CYCLE_LIMIT = 60_000_000;

    // op beat, lowest field last
    typedef struct packed {
        logic [5:0]         pad;
        logic [3:0]         layer;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] ez;
        logic signed [15:0] ey;
        logic signed [15:0] ex;
        logic signed [15:0] oz;
        logic signed [15:0] oy;
        logic signed [15:0] ox;
        logic [1:0]         op;
    } op_beat_t;

    // result beat, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic [16:0] occupied;
        logic [16:0] observed;
        logic        marked;
        logic [1:0]  state;
    } res_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [119:0]         s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_wdata;

    // ------------------------------------------------------------------------
    // Occupancy scoreboard: private map, counters and bounds
    // ------------------------------------------------------------------------
    class occupancy_scoreboard;
        byte unsigned  cells[N_CELLS];
        int unsigned   observed_total;
        int unsigned   occupied_total;
        int unsigned   vox;
        int            lo[3];
        int            hi[3];
        int            last_idx;
        int            errors;
        res_beat_t     expected_q[$];

        function new();
            foreach (cells[i]) cells[i] = CELL_UNKNOWN;
            observed_total = 0;
            occupied_total = 0;
            vox = 200;
            lo = '{-4000, -4500, 0};
            hi = '{7000, 4500, 2400};
            last_idx = 0;
            errors = 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            case (idx)
                REG_VOXEL: vox = v[9:0];
                REG_MIN_X: lo[0] = int'($signed(v));
                REG_MAX_X: hi[0] = int'($signed(v));
                REG_MIN_Y: lo[1] = int'($signed(v));
                REG_MAX_Y: hi[1] = int'($signed(v));
                REG_MIN_Z: lo[2] = int'($signed(v));
                REG_MAX_Z: hi[2] = int'($signed(v));
                default: ;
            endcase
        endfunction

        // point to flat cell index; 0 when outside the map
        function bit cell_of(longint p[3], output int idx);
            longint v;
            longint c[3];
            int     lim[3];
            v = (vox == 0) ? 1 : vox;
            lim = '{N_COLS, N_ROWS, N_LAYERS};
            idx = 0;
            for (int a = 0; a < 3; a++)
            begin
                if (p[a] < lo[a] || p[a] >= hi[a])
                    return 0;
                c[a] = (p[a] - lo[a]) / v;
                if (c[a] >= lim[a])
                    return 0;
            end
            idx = int'((c[2] * N_ROWS + c[1]) * N_COLS + c[0]);
            return 1;
        endfunction

        function void mark(int idx, bit occupy);
            last_idx = idx;
            if (occupy)
            begin
                if (cells[idx] == CELL_UNKNOWN)
                    observed_total++;
                if (cells[idx] != CELL_OCCUPIED)
                    occupied_total++;
                cells[idx] = CELL_OCCUPIED;
            end
            else if (cells[idx] == CELL_UNKNOWN)
            begin
                cells[idx] = CELL_FREE;
                observed_total++;
            end
        endfunction

        // least n with (n*vox)^2 >= 4*len^2, capped
        function int samples_for(longint sq);
            longint v;
            int     n;
            v = (vox == 0) ? 1 : vox;
            n = 1;
            while (n < N_SAMP && longint'(n) * v * longint'(n) * v < 4 * sq)
                n++;
            return n;
        endfunction

        function void note_op(op_beat_t b);
            res_beat_t r;
            longint    o[3];
            longint    d[3];
            longint    e[3];
            longint    p[3];
            longint    sq;
            int        n;
            int        last;
            int        idx;
            r = '0;
            o = '{b.ox, b.oy, b.oz};
            e = '{b.ex, b.ey, b.ez};
            if (b.op == OP_HIT || b.op == OP_FREE)
            begin
                sq = 0;
                for (int a = 0; a < 3; a++)
                begin
                    d[a] = e[a] - o[a];
                    sq += d[a] * d[a];
                end
                if (!(b.op == OP_HIT && sq == 0))
                begin
                    n = samples_for(sq);
                    last = (b.op == OP_HIT) ? n - 1 : n;
                    for (int i = 0; i <= last; i++)
                    begin
                        for (int a = 0; a < 3; a++)
                            p[a] = o[a] + (d[a] * i) / n;
                        if (cell_of(p, idx))
                            mark(idx, 0);
                    end
                    if (b.op == OP_HIT && cell_of(e, idx))
                    begin
                        mark(idx, 1);
                        r.marked = 1'b1;
                    end
                end
            end
            else if (b.op == OP_READ)
            begin
                r.state = cells[(int'(b.layer) * N_ROWS + int'(b.row)) * N_COLS + int'(b.col)];
            end
            r.observed = (observed_total > COUNT_MAX) ? COUNT_MAX : observed_total[16:0];
            r.occupied = (occupied_total > COUNT_MAX) ? COUNT_MAX : occupied_total[16:0];
            expected_q.push_back(r);
        endfunction

        task check_beat(res_beat_t got);
            res_beat_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.state !== want.state)
                report_mismatch("cell_state", got.state, want.state);
            if (got.marked !== want.marked)
                report_mismatch("endpoint_marked", got.marked, want.marked);
            if (got.observed !== want.observed)
                report_mismatch("observed_count", got.observed, want.observed);
            if (got.occupied !== want.occupied)
                report_mismatch("occupied_count", got.occupied, want.occupied);
            if (got.pad !== 3'b000)
                report_mismatch("result fill bits", got.pad, 0);
        endtask
    endclass

    occupancy_scoreboard sb;
    int     send_idle;
    int     recv_stall;
    int     hold_left;
    longint cycles;

    voxel_ray_occupancy_marker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(res_beat_t'(m_tdata));
    end

    // offer one op beat, with random gaps ahead of it
    task send_op(op_beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_op(b);
    endtask

    task wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // write every register while idle
    task set_config(int v, int lx, int hx, int ly, int hy, int lz, int hz);
        int vals[7];
        logic [CFG_IDX_W-1:0] regs[7];
        vals = '{v, lx, hx, ly, hy, lz, hz};
        regs = '{REG_VOXEL, REG_MIN_X, REG_MAX_X, REG_MIN_Y, REG_MAX_Y, REG_MIN_Z, REG_MAX_Z};
        wait_drained();
        for (int i = 0; i < 7; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i][15:0];
            sb.apply_cfg(regs[i], vals[i][15:0]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic op_beat_t make_op(logic [1:0] op, int ox, int oy, int oz,
                                         int ex, int ey, int ez);
        op_beat_t b;
        b = '0;
        b.op = op;
        b.ox = ox[15:0]; b.oy = oy[15:0]; b.oz = oz[15:0];
        b.ex = ex[15:0]; b.ey = ey[15:0]; b.ez = ez[15:0];
        return b;
    endfunction

    function automatic op_beat_t read_of(int idx);
        op_beat_t b;
        b = '0;
        b.op    = OP_READ;
        b.col   = idx[5:0];
        b.row   = idx[11:6];
        b.layer = idx[15:12];
        return b;
    endfunction

    // random op: mostly short rays around the mapped region, some reads
    function automatic op_beat_t random_op();
        op_beat_t b;
        int       v;
        int       o[3];
        int       e[3];
        int       kind;
        b = op_beat_t'({$urandom, $urandom, $urandom, $urandom});
        b.pad = '0;
        kind = $urandom_range(99);
        v = (sb.vox == 0) ? 1 : int'(sb.vox);
        if (kind < 15)
            b.op = OP_READ;
        else if (kind < 30)
            b = read_of(sb.last_idx);
        else if (kind < 33)
            b.op = 2'(OP_NONE);
        else
        begin
            b.op = ($urandom_range(1) == 0) ? OP_HIT : OP_FREE;
            // a few rays keep full random ends (long, clamped count)
            if (kind >= 95)
                return b;
            for (int a = 0; a < 3; a++)
            begin
                if (sb.hi[a] > sb.lo[a])
                    o[a] = sb.lo[a] - 2 * v + int'($urandom_range(sb.hi[a] - sb.lo[a] + 4 * v));
                else
                    o[a] = sb.lo[a] + int'($urandom_range(200)) - 100;
                e[a] = o[a] + int'($urandom_range(6 * v)) - 3 * v;
                if (kind < 36)
                    e[a] = o[a];
            end
            b.ox = o[0][15:0]; b.oy = o[1][15:0]; b.oz = o[2][15:0];
            b.ex = e[0][15:0]; b.ey = e[1][15:0]; b.ez = e[2][15:0];
        end
        return b;
    endfunction

    task random_phase(int count, int mix);
        case (mix % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 34; recv_stall = 34; end
        endcase
        for (int i = 0; i < count; i++)
            send_op(random_op());
    endtask

    initial
    begin
        sb         = new();
        cycles     = 0;
        hold_left  = 0;
        send_idle  = 0;
        recv_stall = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: default bounds
        set_config(200, -4000, 7000, -4500, 4500, 0, 2400);
        send_op(make_op(OP_HIT, 0, 0, 1000, 0, 0, 1000));        // zero length hit
        send_op(make_op(OP_FREE, 100, 100, 100, 100, 100, 100)); // zero length free
        send_op(make_op(OP_HIT, 0, 0, 1000, 1500, 300, 1200));
        send_op(make_op(OP_HIT, 0, 0, 1000, 1500, 300, 1200));   // endpoint already occupied
        send_op(make_op(OP_FREE, 2000, 300, 1200, 1000, 300, 1200)); // crosses occupied cell
        send_op(make_op(OP_HIT, 6000, 0, 1000, 7500, 0, 1000));  // endpoint outside
        send_op(make_op(OP_HIT, -32768, -32768, -32768, 32767, 32767, 32767));
        send_op(make_op(OP_FREE, 32767, 32767, 32767, -32768, -32768, -32768));
        send_op(make_op(OP_HIT, -4000, -4500, 0, 6999, 4499, 2399)); // bound edges
        send_op(make_op(2'(OP_NONE), 1, 2, 3, 4, 5, 6));
        send_op(read_of(sb.last_idx));
        send_op(read_of(0));
        send_op(read_of(N_CELLS - 1));
        send_op(read_of(N_CELLS / 2 + 17));
        begin
            op_beat_t b;
            b = '1;
            b.pad = '0;
            send_op(b);
            b.op = OP_READ;
            send_op(b);
        end

        // random phases over several settings
        set_config(200, -4000, 7000, -4500, 4500, 0, 2400);
        random_phase(160, 0);
        set_config(10, 0, 640, -320, 320, -32768, -32608);
        hold_left = 3000;  // long receiver hold-off while ops keep coming
        random_phase(160, 1);
        set_config(1000, -32768, 32767, -32768, 32767, -32768, 32767);
        random_phase(160, 2);
        set_config(0, -32, 32, 0, 64, 100, 116);
        random_phase(160, 3);
        set_config(1023, 5000, -5000, -20000, 20000, -8000, 8000); // empty x range
        random_phase(120, 0);
        set_config(50, -1600, 1600, -1600, 1600, -400, 400);
        random_phase(160, 3);

        wait_drained();
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
